// ----- design/fbp_pkg.sv -----
// Package for the FIR filter with border passthrough.
// Holds the fixed widths, register codes and word types shared by the modules and testbench.
// Depends on nothing.
package fbp_pkg;

  localparam int MAX_TAPS      = 16;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 16;
  localparam int COEF_FRAC     = 14;
  localparam int MAX_OUT       = MAX_TAPS / 2 + 1;

  localparam int TAP_W         = 5;
  localparam int LEN_W         = 16;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;

  localparam int COEF_PER_BANK = CFG_W / COEF_W;
  localparam int SLOT_W        = $clog2(COEF_PER_BANK);
  localparam int BANK_W        = $clog2(MAX_TAPS / COEF_PER_BANK);

  localparam int HALF_W        = $clog2(MAX_TAPS / 2 + 1);
  localparam int WIN           = MAX_TAPS + 1;
  localparam int WIN_IDX_W     = $clog2(WIN);
  localparam int CNT_W         = $clog2(MAX_OUT);

  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int GRP           = 4;
  localparam int NGRP          = MAX_TAPS / GRP;
  localparam int PART_W        = PROD_W + $clog2(GRP);
  localparam int SUM_W         = PART_W + $clog2(NGRP);
  localparam int Q_W           = SUM_W - COEF_FRAC;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BANK_0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BANK_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BANK_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BANK_3   = 3'd5;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef logic [MAX_TAPS-1:0][COEF_W-1:0] coef_arr_t;

  typedef struct packed {
    sample_t sample;
  } in_word_t;

  typedef struct packed {
    sample_t          filtered;
    logic [LEN_W-1:0] position;
    logic             clipped;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [TAP_W-1:0]  taps;
    logic [HALF_W-1:0] half;
    logic [LEN_W-1:0]  len;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] position;
    logic             pass;
    sample_t          pass_val;
    logic             last;
  } meta_t;

  typedef struct packed {
    meta_t                               meta;
    logic [MAX_TAPS-1:0][SAMPLE_W-1:0]   lane;
  } lane_word_t;

endpackage

// ----- design/fbp_stream_if.sv -----
// Valid/ready stream channel carrying one word of a chosen payload type.
// Uses no package; the payload type is given at instantiation.
interface fbp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/fbp_cfg.sv -----
// Configuration registers: tap count, series length and coefficient banks.
// Delivers the clamped tap count, its half and the coefficients; uses fbp_pkg.
module fbp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbp_pkg::CFG_W-1:0]     cfg_data_i,
  output fbp_pkg::cfg_t                 cfg_o,
  output fbp_pkg::coef_arr_t            coef_o
);
  import fbp_pkg::*;

  logic [TAP_W-1:0]     tap_q;
  logic [LEN_W-1:0]     len_q;
  coef_arr_t            coef_q;
  logic [CFG_IDX_W-1:0] bank_diff;
  logic [BANK_W-1:0]    bank_sel;
  logic [TAP_W-1:0]     taps;

  assign bank_diff = cfg_idx_i - REG_COEF_BANK_0;
  assign bank_sel  = bank_diff[BANK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q     <= TAP_W'(1);
      len_q     <= LEN_W'(1);
      coef_q    <= coef_arr_t'(COEF_ONE);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_COUNT: begin
          tap_q <= cfg_data_i[TAP_W-1:0];
        end
        REG_SERIES_LENGTH: begin
          len_q <= cfg_data_i[LEN_W-1:0];
        end
        REG_COEF_BANK_0, REG_COEF_BANK_1, REG_COEF_BANK_2, REG_COEF_BANK_3: begin
          for (int j = 0; j < COEF_PER_BANK; j++) begin
            coef_q[{bank_sel, SLOT_W'(j)}] <= cfg_data_i[j*COEF_W +: COEF_W];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (tap_q == '0) begin
      taps = TAP_W'(1);
    end else if (tap_q > TAP_W'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = tap_q;
    end
  end

  assign cfg_o.taps = taps;
  assign cfg_o.half = HALF_W'(taps >> 1);
  assign cfg_o.len  = len_q;
  assign coef_o     = coef_q;

endmodule

// ----- design/fbp_sched.sv -----
// Series bookkeeping, delay line and output sequencer.
// Turns each accepted sample into a run of output jobs, a tap window per cycle unless stalled; uses fbp_pkg.
module fbp_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbp_pkg::cfg_t       cfg_i,
  fbp_stream_if.sink          in_i,
  input  logic                take_i,
  output fbp_pkg::lane_word_t lw_o,
  output logic                lw_valid_o
);
  import fbp_pkg::*;

  localparam int TGT_W = LEN_W + 2;
  localparam int AGE_W = WIN_IDX_W + 2;

  logic [LEN_W-1:0]                  idx_q, idx_d, nxt_q, nxt_d;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] dline_q;
  logic                              busy_q, busy_d;
  logic [LEN_W-1:0]                  x_q, x_d;
  logic [WIN_IDX_W-1:0]              d_q, d_d;
  logic [CNT_W-1:0]                  rem_q, rem_d;
  logic [TAP_W-1:0]                  t_q;
  logic [HALF_W-1:0]                 h_q;
  logic [LEN_W-1:0]                  len_q;
  logic                              last_q;
  logic [WIN-1:0][SAMPLE_W-1:0]      w_q;
  logic                              s1_v_q;
  lane_word_t                        lw_q, lw_d;

  logic                              en1, issue, fin, acc;
  logic [LEN_W:0]                    i_p1;
  logic                              is_last;
  logic [LEN_W-1:0]                  len_eff;
  logic signed [TGT_W-1:0]           i_s, nxt_s, target, lo, start, span, lag;
  logic                              have;
  logic [LEN_W:0]                    x_ext;
  logic [WIN_IDX_W:0]                base;
  logic signed [AGE_W-1:0]           age [MAX_TAPS];

  assign en1         = !s1_v_q || take_i;
  assign issue       = busy_q && en1;
  assign fin         = (rem_q == '0);
  assign in_i.ready  = !busy_q || (issue && fin);
  assign acc         = in_i.valid && in_i.ready;

  always_comb begin
    i_p1    = {1'b0, idx_q} + (LEN_W+1)'(1);
    is_last = i_p1 >= {1'b0, cfg_i.len};
    len_eff = is_last ? i_p1[LEN_W-1:0] : cfg_i.len;
    i_s     = $signed({2'b00, idx_q});
    nxt_s   = $signed({2'b00, nxt_q});
    target  = is_last ? i_s : i_s - $signed(TGT_W'(cfg_i.half));
    lo      = target - $signed(TGT_W'(MAX_OUT - 1));
    start   = (nxt_s < lo) ? lo : nxt_s;
    have    = target >= start;
    span    = target - start;
    lag     = i_s - start;
  end

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    d_d    = d_q;
    rem_d  = rem_q;
    if (acc) begin
      busy_d = have;
      x_d    = start[LEN_W-1:0];
      d_d    = lag[WIN_IDX_W-1:0];
      rem_d  = span[CNT_W-1:0];
    end else if (issue) begin
      if (fin) begin
        busy_d = 1'b0;
      end else begin
        x_d   = x_q + LEN_W'(1);
        d_d   = d_q - WIN_IDX_W'(1);
        rem_d = rem_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    nxt_d = nxt_q;
    if (acc) begin
      if (is_last) begin
        idx_d = '0;
        nxt_d = '0;
      end else begin
        idx_d = i_p1[LEN_W-1:0];
        if (have) begin
          nxt_d = target[LEN_W-1:0] + LEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    x_ext             = {1'b0, x_q};
    lw_d.meta.position = x_q;
    lw_d.meta.pass     = (x_ext < (LEN_W+1)'(h_q)) ||
                         ((x_ext + (LEN_W+1)'(h_q)) >= {1'b0, len_q});
    lw_d.meta.pass_val = w_q[d_q];
    lw_d.meta.last     = last_q && (x_q == len_q - LEN_W'(1));
    base               = (WIN_IDX_W+1)'(d_q) + (WIN_IDX_W+1)'(h_q);
    for (int k = 0; k < MAX_TAPS; k++) begin
      age[k] = $signed({1'b0, base}) - $signed(AGE_W'(k));
      if ((TAP_W'(k) < t_q) && (age[k] >= $signed(AGE_W'(0))) &&
          (age[k] <= $signed(AGE_W'(WIN - 1)))) begin
        lw_d.lane[k] = w_q[age[k][WIN_IDX_W-1:0]];
      end else begin
        lw_d.lane[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      nxt_q   <= '0;
      dline_q <= '0;
      busy_q  <= 1'b0;
      s1_v_q  <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      nxt_q  <= nxt_d;
      busy_q <= busy_d;
      if (acc) begin
        dline_q <= {dline_q[MAX_TAPS-2:0], in_i.payload.sample};
      end
      if (en1) begin
        s1_v_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    if (acc) begin
      t_q    <= cfg_i.taps;
      h_q    <= cfg_i.half;
      len_q  <= len_eff;
      last_q <= is_last;
      w_q    <= {dline_q, in_i.payload.sample};
    end
    if (issue) begin
      lw_q <= lw_d;
    end
  end

  assign lw_o       = lw_q;
  assign lw_valid_o = s1_v_q;

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q <= CNT_W'(MAX_OUT - 1)))
    else $error("output run longer than the flush limit");

  a_window_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (d_q <= WIN_IDX_W'(MAX_TAPS)))
    else $error("passthrough sample lies outside the stored window");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && busy_q) |-> (issue && fin))
    else $error("new word taken before the current run was issued");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !fin && !acc) |=> busy_q)
    else $error("output run dropped before its end");

endmodule

// ----- design/fbp_mac.sv -----
// Multiply-accumulate pipeline: tap products, adder tree, rounding and saturation.
// Ends in the result register that drives the output channel; uses fbp_pkg.
module fbp_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbp_pkg::coef_arr_t  coef_i,
  input  fbp_pkg::lane_word_t lw_i,
  input  logic                lw_valid_i,
  output logic                take_o,
  fbp_stream_if.source        out_o
);
  import fbp_pkg::*;

  logic                    s2_v_q, s3_v_q, s4_v_q, out_v_q;
  meta_t                   s2_meta_q, s3_meta_q, s4_meta_q;
  logic signed [PROD_W-1:0] prod_d [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];
  logic signed [PART_W-1:0] part_d [NGRP];
  logic signed [PART_W-1:0] part_q [NGRP];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  out_word_t               out_d, out_q;
  logic                    en_o, en4, en3;

  logic [Q_W-1:0]          q;
  logic [COEF_FRAC-1:0]    rem;
  logic                    inc, ovf;
  logic signed [Q_W:0]     qr;
  logic [Q_W-SAMPLE_W+1:0] top;
  sample_t                 sat, val;

  assign en_o   = !out_v_q || out_o.ready;
  assign en4    = !s4_v_q || en_o;
  assign en3    = !s3_v_q || en4;
  assign take_o = !s2_v_q || en3;

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      prod_d[k] = $signed(lw_i.lane[k]) * $signed(coef_i[k]);
    end
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        part_d[g] = part_d[g] + PART_W'(prod_q[g*GRP + j]);
      end
    end
    sum_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_d = sum_d + SUM_W'(part_q[g]);
    end
  end

  // Round half to even, then saturate to the sample width.
  always_comb begin
    q   = sum_q[SUM_W-1:COEF_FRAC];
    rem = sum_q[COEF_FRAC-1:0];
    inc = rem[COEF_FRAC-1] && ((|rem[COEF_FRAC-2:0]) || q[0]);
    qr  = $signed({q[Q_W-1], q}) + $signed({{Q_W{1'b0}}, inc});
    top = qr[Q_W:SAMPLE_W-1];
    ovf = !((&top) || (~|top));
    sat = qr[Q_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    val = ovf ? sat : qr[SAMPLE_W-1:0];
    out_d.filtered = s4_meta_q.pass ? s4_meta_q.pass_val : val;
    out_d.position = s4_meta_q.position;
    out_d.clipped  = !s4_meta_q.pass && ovf;
    out_d.last     = s4_meta_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take_o) begin
        s2_v_q <= lw_valid_i;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en4) begin
        s4_v_q <= s3_v_q;
      end
      if (en_o) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && lw_valid_i) begin
      prod_q    <= prod_d;
      s2_meta_q <= lw_i.meta;
    end
    if (en3 && s2_v_q) begin
      part_q    <= part_d;
      s3_meta_q <= s2_meta_q;
    end
    if (en4 && s3_v_q) begin
      sum_q     <= sum_d;
      s4_meta_q <= s3_meta_q;
    end
    if (en_o && s4_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && lw_valid_i) |=> s2_v_q)
    else $error("lane word taken but lost at the product stage");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !en3) |=> (s2_v_q && $stable(s2_meta_q)))
    else $error("stalled product stage changed");

  a_sum_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && en_o) |=> out_v_q)
    else $error("finished sum did not reach the result register");

endmodule

// ----- design/fir_filter_border_passthrough_core.sv -----
// Top level of the direct-form FIR filter with border passthrough.
// Joins fbp_cfg, fbp_sched and fbp_mac; uses fbp_pkg and fbp_stream_if.
//
// One signed sample is taken per cycle while the sequencer is not busy. For tap count
// T and H = T / 2, output x is the Q2.14 convolution over samples x-H .. x-H+T-1,
// rounded half to even and saturated, and outputs within H of either end of the
// series pass through unchanged. Output x appears once sample x+H has been taken,
// and the last sample of a series releases all remaining outputs. The sequencer
// issues one output per cycle while the sixteen-lane multiply and adder-tree
// pipeline takes them, and takes no new sample while outputs remain to be issued:
// a sample releases one output in steady state, up to H+1 at the end of a series,
// and at most nine after a tap count change part way through a series. Results
// pass the lane, product, partial-sum, sum and result registers, and a waiting
// result does not stop new samples while the pipeline still has empty stages.
module fir_filter_border_passthrough_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbp_pkg::CFG_W-1:0]     cfg_data_i,
  fbp_stream_if.sink                    in_i,
  fbp_stream_if.source                  out_o
);
  import fbp_pkg::*;

  cfg_t       cfg;
  coef_arr_t  coef;
  lane_word_t lw;
  logic       lw_valid;
  logic       take;

  fbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .coef_o     (coef)
  );

  fbp_sched u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_i       (in_i),
    .take_i     (take),
    .lw_o       (lw),
    .lw_valid_o (lw_valid)
  );

  fbp_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .lw_i       (lw),
    .lw_valid_i (lw_valid),
    .take_o     (take),
    .out_o      (out_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fir_filter_border_passthrough_core: random and directed sample series,
// predicted word by word against a behavioural FIR with border passthrough.
// Depends on fbp_pkg, fbp_stream_if and the core itself.
module testbench;
  import fbp_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int STALL_PCT      = 11;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT        = 30;
  localparam int QUIET_FROM     = 110;
  localparam int QUIET_TO       = 150;
  localparam int TOTAL_ITEMS    = 170;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint SAT_HI     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO     = -SAT_HI - 1;
  localparam longint FRAC_MASK  = (64'sd1 <<< COEF_FRAC) - 1;
  localparam longint ROUND_HALF = 64'sd1 <<< (COEF_FRAC - 1);

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fbp_stream_if #(.payload_t(in_word_t))  in_if ();
  fbp_stream_if #(.payload_t(out_word_t)) out_if ();

  fir_filter_border_passthrough_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  logic [TAP_W-1:0] tap_reg;
  logic [LEN_W-1:0] len_reg;
  logic [CFG_W-1:0] coef_reg [NGRP];
  sample_t          hist [MAX_TAPS] = '{default: '0};
  int               smp_idx = 0;
  int               out_idx = 0;

  out_word_t expected_words [$];
  sample_t   pending_samples [$];

  int   pushed_cnt;
  int   accepted_cnt;
  int   out_cnt;
  int   fail_cnt = 0;
  int   settings_cnt;
  int   stall_cyc = 0;
  int   hold_left;
  logic hold_active;
  logic hold_done;
  logic quiet;

  assign quiet = (accepted_cnt >= QUIET_FROM) && (accepted_cnt < QUIET_TO);

  function automatic sample_t hist_at(int j, int i, sample_t cur);
    int age;
    age = i - j;
    if (age == 0) return cur;
    if (age >= 1 && age <= MAX_TAPS) return hist[age - 1];
    return '0;
  endfunction

  function automatic longint coef_at(int k);
    logic signed [COEF_W-1:0] c;
    c = coef_reg[k / COEF_PER_BANK][(k % COEF_PER_BANK) * COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  function automatic void fir_predict(sample_t cur);
    int        t, h, i, len, target, first, x, k;
    bit        is_last, clip;
    longint    acc, q, rem, val;
    out_word_t w;
    t = int'(tap_reg);
    if (t < 1) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    h = t / 2;
    i = smp_idx;
    len = int'(len_reg);
    is_last = (i + 1 >= len);
    if (is_last) len = i + 1;
    target = is_last ? len - 1 : i - h;
    first = out_idx;
    if (first < target + 1 - MAX_OUT) first = target + 1 - MAX_OUT;
    for (x = first; x <= target; x++) begin
      clip = 1'b0;
      if (x < h || x + h >= len) begin
        val = longint'(hist_at(x, i, cur));
      end else begin
        acc = 0;
        for (k = 0; k < t; k++) acc += longint'(hist_at(x - h + k, i, cur)) * coef_at(k);
        q = acc >>> COEF_FRAC;
        rem = acc & FRAC_MASK;
        if (rem > ROUND_HALF || (rem == ROUND_HALF && q[0])) q++;
        if (q > SAT_HI) begin
          q = SAT_HI;
          clip = 1'b1;
        end
        if (q < SAT_LO) begin
          q = SAT_LO;
          clip = 1'b1;
        end
        val = q;
      end
      w.filtered = val[SAMPLE_W-1:0];
      w.position = x[LEN_W-1:0];
      w.clipped  = clip;
      w.last     = is_last && (x == len - 1);
      expected_words.insert(expected_words.size(), w);
    end
    if (target >= first) out_idx = target + 1;
    for (k = MAX_TAPS - 1; k > 0; k--) hist[k] = hist[k - 1];
    hist[0] = cur;
    if (is_last) begin
      smp_idx = 0;
      out_idx = 0;
    end else begin
      smp_idx = (i + 1) & 16'hFFFF;
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      2: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_coef_bank(int style);
    logic [CFG_W-1:0] bank;
    for (int s = 0; s < COEF_PER_BANK; s++) begin
      case (style)
        0: bank[s*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 8191)) - 4096);
        1: case ($urandom_range(3))
             0: bank[s*COEF_W +: COEF_W] = 16'h7FFF;
             1: bank[s*COEF_W +: COEF_W] = 16'h8000;
             2: bank[s*COEF_W +: COEF_W] = COEF_ONE;
             default: bank[s*COEF_W +: COEF_W] = '0;
           endcase
        default: bank[s*COEF_W +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return bank;
  endfunction

  task automatic push_sample(input sample_t s);
    pending_samples.insert(pending_samples.size(), s);
    pushed_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_TAP_COUNT:     tap_reg = data[TAP_W-1:0];
      REG_SERIES_LENGTH: len_reg = data[LEN_W-1:0];
      REG_COEF_BANK_0:   coef_reg[0] = data;
      REG_COEF_BANK_1:   coef_reg[1] = data;
      REG_COEF_BANK_2:   coef_reg[2] = data;
      REG_COEF_BANK_3:   coef_reg[3] = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt || expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
      accepted_cnt  <= 0;
    end else begin
      if (!in_if.valid || in_if.ready) begin
        if (in_if.valid) begin
          fir_predict(in_if.payload.sample);
          accepted_cnt <= accepted_cnt + 1;
        end
        if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= STALL_PCT)) begin
          in_if.payload <= '{sample: pending_samples.pop_front()};
          in_if.valid   <= 1'b1;
        end else begin
          in_if.valid   <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_cnt      <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_cnt <= out_cnt + 1;
        if (expected_words.size() == 0) begin
          note_failure($sformatf("Unexpected word: filtered %0d position %0d clipped %0b last %0b",
                                 out_if.payload.filtered, out_if.payload.position,
                                 out_if.payload.clipped, out_if.payload.last));
        end else if (out_if.payload.filtered !== expected_words[0].filtered ||
                     out_if.payload.position !== expected_words[0].position ||
                     out_if.payload.clipped  !== expected_words[0].clipped  ||
                     out_if.payload.last     !== expected_words[0].last) begin
          note_failure($sformatf({"Mismatch: expected filtered %0d position %0d clipped %0b ",
                                  "last %0b, got filtered %0d position %0d clipped %0b last %0b"},
                                 expected_words[0].filtered, expected_words[0].position,
                                 expected_words[0].clipped, expected_words[0].last,
                                 out_if.payload.filtered, out_if.payload.position,
                                 out_if.payload.clipped, out_if.payload.last));
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
      end
      out_if.ready <= !hold_active && (quiet || $urandom_range(99) >= STALL_PCT);
    end
  end

  // A single long hold-off on the output side while the input keeps offering words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_left   <= 0;
    end else if (hold_active) begin
      if (hold_left == 1) hold_active <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_active <= 1'b1;
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= WATCHDOG_LIMIT) begin
        $display("fir_filter_border_passthrough_core verification failed");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  initial begin
    int               taps, len, n, k, style;
    logic [CFG_W-1:0] data;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_TAP_COUNT;
    cfg_data_i   = '0;
    pushed_cnt   = 0;
    settings_cnt = 1;
    tap_reg      = TAP_W'(1);
    len_reg      = LEN_W'(1);
    coef_reg[0]  = CFG_W'(COEF_ONE);
    coef_reg[1]  = '0;
    coef_reg[2]  = '0;
    coef_reg[3]  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one tap of unity gain, series of one sample.
    push_sample(sample_t'(16'h7FFF));
    push_sample(sample_t'(16'h8000));
    settle();

    // Half-gain single tap exposes ties in the rounding; length zero gives one-sample series.
    settings_cnt++;
    write_reg(REG_TAP_COUNT, {{(CFG_W-TAP_W){1'b1}}, TAP_W'(1)});
    write_reg(REG_SERIES_LENGTH, {{(CFG_W-LEN_W){1'b1}}, LEN_W'(0)});
    data = {$urandom, $urandom};
    data[COEF_W-1:0] = 16'h2000;
    write_reg(REG_COEF_BANK_0, data);
    push_sample(sample_t'(1));
    push_sample(sample_t'(3));
    push_sample(sample_t'(-1));
    push_sample(sample_t'(-3));
    push_sample(sample_t'(-32767));
    settle();

    // Sixteen taps at full positive gain drive the middle word into saturation.
    settings_cnt++;
    write_reg(REG_TAP_COUNT, CFG_W'(MAX_TAPS));
    write_reg(REG_SERIES_LENGTH, CFG_W'(17));
    for (int b = 0; b < NGRP; b++) write_reg(REG_COEF_BANK_0 + CFG_IDX_W'(b), 64'h7FFF7FFF7FFF7FFF);
    repeat (16) push_sample(sample_t'(16'h7FFF));
    push_sample(sample_t'(16'h8000));
    settle();

    // Longest series, filled against a stalled output, then cut short by a lower length.
    settings_cnt++;
    write_reg(REG_SERIES_LENGTH, CFG_W'(16'hFFFF));
    for (int b = 0; b < NGRP; b++) write_reg(REG_COEF_BANK_0 + CFG_IDX_W'(b), rand_coef_bank(0));
    repeat (40) push_sample(rand_sample());
    settle();
    write_reg(REG_SERIES_LENGTH, CFG_W'(5));
    push_sample(rand_sample());
    settle();

    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});

    while (pushed_cnt < TOTAL_ITEMS) begin
      settings_cnt++;
      if ($urandom_range(9) == 0) taps = $urandom_range(1) ? 0 : $urandom_range(MAX_TAPS + 1, 31);
      else taps = $urandom_range(1, MAX_TAPS);
      data = {$urandom, $urandom};
      data[TAP_W-1:0] = TAP_W'(taps);
      write_reg(REG_TAP_COUNT, data);
      case ($urandom_range(9))
        0: len = 0;
        1: len = $urandom_range(25, 48);
        default: len = $urandom_range(1, 20);
      endcase
      data = {$urandom, $urandom};
      data[LEN_W-1:0] = LEN_W'(len);
      write_reg(REG_SERIES_LENGTH, data);
      if ($urandom_range(2) == 0) begin
        style = $urandom_range(2);
        for (int b = 0; b < NGRP; b++)
          write_reg(REG_COEF_BANK_0 + CFG_IDX_W'(b), rand_coef_bank(style));
      end
      n = (len == 0) ? $urandom_range(1, 3) : len;
      if (n > 2 && $urandom_range(3) == 0) begin
        k = $urandom_range(1, n - 1);
        repeat (k) push_sample(rand_sample());
        settle();
        if ($urandom_range(1)) write_reg(REG_TAP_COUNT, CFG_W'($urandom_range(0, 31)));
        else write_reg(REG_SERIES_LENGTH, CFG_W'($urandom_range(0, k)));
        repeat (n - k) push_sample(rand_sample());
      end else begin
        repeat (n) push_sample(rand_sample());
      end
      settle();
    end

    $display("Run covered %0d samples and %0d filtered words over %0d register settings,",
             accepted_cnt, out_cnt, settings_cnt);
    $display("including tap counts out of range, zero and maximum lengths and mid-series changes.");
    if (fail_cnt == 0 && expected_words.size() == 0) begin
      $display("fir_filter_border_passthrough_core verification clean");
    end else begin
      $display("fir_filter_border_passthrough_core verification failed");
    end
    $finish;
  end

endmodule
